>>> src/gcb_pkg.sv
// Package for the grapheme cluster boundary core: property classes, FSM states.
// No dependencies.
`timescale 1ns / 1ps
package gcb_pkg;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned CLS_W  = 4;
    localparam int unsigned MASK_W = 16;
    localparam int unsigned CNT_W  = 12;

    localparam logic [CLS_W-1:0] CLS_CR          = 4'd0;
    localparam logic [CLS_W-1:0] CLS_LF          = 4'd1;
    localparam logic [CLS_W-1:0] CLS_CONTROL     = 4'd2;
    localparam logic [CLS_W-1:0] CLS_EXTEND      = 4'd3;
    localparam logic [CLS_W-1:0] CLS_ZWJ         = 4'd4;
    localparam logic [CLS_W-1:0] CLS_RI          = 4'd5;
    localparam logic [CLS_W-1:0] CLS_PREPEND     = 4'd6;
    localparam logic [CLS_W-1:0] CLS_SPACINGMARK = 4'd7;
    localparam logic [CLS_W-1:0] CLS_L           = 4'd8;
    localparam logic [CLS_W-1:0] CLS_V           = 4'd9;
    localparam logic [CLS_W-1:0] CLS_T           = 4'd10;
    localparam logic [CLS_W-1:0] CLS_LV          = 4'd11;
    localparam logic [CLS_W-1:0] CLS_LVT         = 4'd12;
    localparam logic [CLS_W-1:0] CLS_EXTPICT     = 4'd13;

    localparam logic [CP_W-1:0] PRINT_LO = 21'h20;
    localparam logic [CP_W-1:0] PRINT_HI = 21'h7E;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } t_state;

    typedef struct packed {
        logic load_in;   // capture query, start scan
        logic scan;      // issue read of next slot
        logic decide;    // apply rules, update flags
        logic out_valid; // result held
    } t_cmd;

    typedef struct packed {
        logic scan_last;  // this read is the last slot
        logic scan_empty; // nothing to scan
        logic ascii;      // printable pair shortcut
    } t_stat;
endpackage

>>> src/gcb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module gcb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> src/gcb_ctrl.sv
// Controller FSM for the boundary core: sequences load, scan, decide, output.
// Depends on gcb_pkg.
`timescale 1ns / 1ps
module gcb_ctrl import gcb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_query,  // a query word accepted this cycle
    input  logic  i_out_rdy,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);
    t_state r_state, n_state;
    logic   r_hold, n_hold;
    logic   w_free;

    // output register free, or emptied at this edge
    assign w_free = !r_hold || i_out_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_hold  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hold  <= n_hold;
        end
    end

    always_comb begin
        n_state = r_state;
        n_hold  = r_hold;
        case (r_state)
            ST_IDLE:   if (i_query) n_state = ST_SCAN;
            ST_SCAN: begin
                if (i_stat.ascii || i_stat.scan_empty) n_state = ST_DECIDE;
                else if (i_stat.scan_last) n_state = ST_DRAIN;
            end
            ST_DRAIN:  n_state = ST_DECIDE;
            ST_DECIDE: if (w_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
        if (r_state == ST_DECIDE && w_free) n_hold = 1'b1;
        else if (i_out_rdy)                 n_hold = 1'b0;
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.load_in   = (r_state == ST_IDLE) && i_query;
        o_cmd.scan      = (r_state == ST_SCAN) && !i_stat.ascii && !i_stat.scan_empty;
        o_cmd.decide    = (r_state == ST_DECIDE) && w_free;
        o_cmd.out_valid = r_hold;
        o_busy          = (r_state != ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (i_rst_n && o_cmd.decide) begin
            assert (n_state == ST_IDLE) else $error("decide must return to idle");
        end
    end
    property p_out_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_hold && !i_out_rdy) |=> r_hold;
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result dropped");
    property p_no_load_busy;
        @(posedge i_clk) disable iff (!i_rst_n)
            o_busy |-> !o_cmd.load_in;
    endproperty
    a_no_load_busy: assert property (p_no_load_busy) else $error("load while busy");
    property p_drain;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == ST_DRAIN) |=> (r_state == ST_DECIDE);
    endproperty
    a_drain: assert property (p_drain) else $error("drain sequence broken");
endmodule

>>> src/gcb_dp.sv
// Datapath for the boundary core: range table, scan counter, class masks, rules.
// Depends on gcb_pkg and gcb_ram.
`timescale 1ns / 1ps
module gcb_dp import gcb_pkg::*; #(
    parameter int unsigned TABLE_ENTRIES = 2048
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load_we,
    input  logic [10:0]     i_entry_index,
    input  logic [CP_W-1:0] i_range_low,
    input  logic [CP_W-1:0] i_range_high,
    input  logic [CLS_W-1:0] i_prop_class,
    input  logic [CP_W-1:0] i_cp_left,
    input  logic [CP_W-1:0] i_cp_right,
    input  logic            i_start_text,
    input  logic [CNT_W-1:0] i_table_count,
    input  t_cmd            i_cmd,
    output t_stat           o_stat,
    output logic            o_is_boundary,
    output logic            o_ri_odd,
    output logic            o_emoji
);
    localparam int unsigned AW  = $clog2(TABLE_ENTRIES);
    localparam int unsigned EW  = 2 * CP_W + CLS_W;
    localparam int unsigned CW  = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned XW  = (CW > CNT_W) ? CW : CNT_W;
    localparam logic [XW-1:0] ENT = XW'(TABLE_ENTRIES);

    logic [EW-1:0] w_rdata;
    logic [AW-1:0] r_addr;
    logic [XW-1:0] r_lim;
    logic [CP_W-1:0] r_cpl, r_cpr;
    logic r_rv;
    logic [MASK_W-1:0] r_ma, r_mb;
    logic r_ri, r_em, r_brk;
    logic r_start;
    logic w_we;
    logic [XW-1:0] w_cnt;

    // loads beyond the table are dropped
    assign w_we = i_load_we && (XW'(i_entry_index) < ENT);

    gcb_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_tab (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(AW'(i_entry_index)),
        .i_wdata({i_range_low, i_range_high, i_prop_class}),
        .i_raddr(r_addr),
        .o_rdata(w_rdata)
    );

    assign w_cnt = (XW'(i_table_count) > ENT) ? ENT : XW'(i_table_count);

    assign o_stat.ascii = (r_cpl >= PRINT_LO) && (r_cpl <= PRINT_HI)
                       && (r_cpr >= PRINT_LO) && (r_cpr <= PRINT_HI);
    assign o_stat.scan_empty = (r_lim == '0);
    assign o_stat.scan_last  = (XW'(r_addr) + XW'(1) >= r_lim);

    logic [CP_W-1:0] w_lo, w_hi;
    logic [CLS_W-1:0] w_cl;
    logic [MASK_W-1:0] w_bit;
    assign {w_lo, w_hi, w_cl} = w_rdata;
    assign w_bit = MASK_W'(1) << w_cl;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cpl  <= i_cp_left;
            r_cpr  <= i_cp_right;
            r_addr <= '0;
            r_lim  <= w_cnt;
            r_ma   <= '0;
            r_mb   <= '0;
        end else begin
            if (i_cmd.scan) r_addr <= r_addr + AW'(1);
            if (r_rv) begin
                if (r_cpl >= w_lo && r_cpl <= w_hi) r_ma <= r_ma | w_bit;
                if (r_cpr >= w_lo && r_cpr <= w_hi) r_mb <= r_mb | w_bit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rv <= 1'b0;
        else          r_rv <= i_cmd.scan;
    end

    logic ri0, em0, n_ri, n_em, n_brk;
    logic [MASK_W-1:0] a, b;
    always_comb begin
        a = r_ma;
        b = r_mb;
        ri0 = r_ri;
        em0 = r_em;
        if (r_start) begin
            ri0 = 1'b0;
            em0 = 1'b0;
        end
        n_ri = ri0;
        n_em = em0;
        n_brk = 1'b1;
        if (!o_stat.ascii) begin
            if (b[CLS_RI]) n_ri = a[CLS_RI] ? !ri0 : 1'b0;
            if (!em0 && a[CLS_EXTPICT] && (b[CLS_ZWJ] || b[CLS_EXTEND]))
                n_em = 1'b1;
            else if (em0 && ((a[CLS_ZWJ] && b[CLS_EXTPICT]) ||
                             (a[CLS_EXTEND] && (b[CLS_EXTEND] || b[CLS_ZWJ])) ||
                             (a[CLS_EXTPICT] && (b[CLS_ZWJ] || b[CLS_EXTEND]))))
                n_em = 1'b1;
            else
                n_em = 1'b0;
            // rule chain sees the flags as already updated for this pair
            if (a[CLS_CR] && b[CLS_LF]) n_brk = 1'b0;
            else if (a[CLS_CONTROL] || a[CLS_CR] || a[CLS_LF]) n_brk = 1'b1;
            else if (b[CLS_CONTROL] || b[CLS_CR] || b[CLS_LF]) n_brk = 1'b1;
            else if (a[CLS_L] && (b[CLS_L] || b[CLS_V] || b[CLS_LV] || b[CLS_LVT]))
                n_brk = 1'b0;
            else if ((a[CLS_LV] || a[CLS_V]) && (b[CLS_V] || b[CLS_T])) n_brk = 1'b0;
            else if ((a[CLS_LVT] || a[CLS_T]) && b[CLS_T]) n_brk = 1'b0;
            else if (b[CLS_EXTEND] || b[CLS_ZWJ]) n_brk = 1'b0;
            else if (b[CLS_SPACINGMARK]) n_brk = 1'b0;
            else if (a[CLS_PREPEND]) n_brk = 1'b0;
            else if (n_em && a[CLS_ZWJ] && b[CLS_EXTPICT]) n_brk = 1'b0;
            else if (a[CLS_RI] && b[CLS_RI] && n_ri) n_brk = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) r_start <= i_start_text;
        if (i_cmd.decide) r_brk <= n_brk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ri <= 1'b0;
            r_em <= 1'b0;
        end else if (i_cmd.decide) begin
            r_ri <= n_ri;
            r_em <= n_em;
        end
    end

    assign o_is_boundary = r_brk;
    assign o_ri_odd      = r_ri;
    assign o_emoji       = r_em;

    property p_ascii_keeps;
        @(posedge i_clk) disable iff (!i_rst_n)
            (i_cmd.decide && o_stat.ascii && !r_start) |=> ($stable(r_ri) && $stable(r_em));
    endproperty
    a_ascii_keeps: assert property (p_ascii_keeps) else $error("ascii changed flags");
    property p_ascii_brk;
        @(posedge i_clk) disable iff (!i_rst_n)
            (i_cmd.decide && o_stat.ascii) |=> r_brk;
    endproperty
    a_ascii_brk: assert property (p_ascii_brk) else $error("ascii pair not a break");
    property p_start_clear;
        @(posedge i_clk) disable iff (!i_rst_n)
            (i_cmd.decide && r_start && o_stat.ascii) |=> (!r_ri && !r_em);
    endproperty
    a_start_clear: assert property (p_start_clear) else $error("start_text not cleared");
endmodule

>>> src/grapheme_cluster_boundary_core.sv
// Top level of the grapheme cluster boundary core: ports, controller, datapath.
// Depends on gcb_pkg, gcb_ctrl, gcb_dp, gcb_ram.
//
// Usage: every input word on the s_axis channel is either a table load
// (s_axis_tuser 0) or a boundary query (s_axis_tuser 1). A load writes one
// range entry into the table at the accepting edge and gives no result. A query
// scans the first table_count entries (capped at TABLE_ENTRIES) of the range
// RAM, one entry per cycle through its single read port, ORs the classes of all
// matching ranges into two masks, then applies rules GB3 to GB999 and returns
// one word on m_axis: {emoji_out, ri_odd_out, is_boundary}.
// A query whose code points are both printable ASCII, or taken while
// table_count is 0, skips the scan and goes straight to the decision.
// s_axis_tready is low from acceptance until the decision. The result waits in
// the output register; loads and the next query are taken meanwhile, and a
// query reaching its decision while the previous result is still held waits
// there until m_axis_tready takes that result. Reset clears the flags,
// table_count and the controller; table contents are undefined until loaded.
// table_count is written via i_cfg_we; the user must write it only while idle,
// as the block itself does not enforce this.
`timescale 1ns / 1ps
module grapheme_cluster_boundary_core import gcb_pkg::*; #(
    parameter int unsigned TABLE_ENTRIES = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [11:0] i_cfg_wdata,      // table_count
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic        s_axis_tuser,     // [0] req_type
    // [10:0] entry_index, [31:11] range_low, [52:32] range_high,
    // [56:53] prop_class, [77:57] cp_left, [98:78] cp_right,
    // [99] start_text, [103:100] zero
    input  logic [103:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] is_boundary, [1] ri_odd_out, [2] emoji_out, [7:3] zero
    output logic [7:0]  m_axis_tdata
);
    logic [CNT_W-1:0] r_table_count;
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_busy, w_acc, w_brk, w_ri, w_em;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_table_count <= '0;
        else if (i_cfg_we) r_table_count <= i_cfg_wdata;
    end

    assign s_axis_tready = !w_busy;
    assign w_acc = s_axis_tvalid && s_axis_tready;

    gcb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_query  (w_acc && s_axis_tuser),
        .i_out_rdy(m_axis_tready),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .o_busy   (w_busy)
    );

    gcb_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_we    (w_acc && !s_axis_tuser),
        .i_entry_index(s_axis_tdata[10:0]),
        .i_range_low  (s_axis_tdata[31:11]),
        .i_range_high (s_axis_tdata[52:32]),
        .i_prop_class (s_axis_tdata[56:53]),
        .i_cp_left    (s_axis_tdata[77:57]),
        .i_cp_right   (s_axis_tdata[98:78]),
        .i_start_text (s_axis_tdata[99]),
        .i_table_count(r_table_count),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_is_boundary(w_brk),
        .o_ri_odd     (w_ri),
        .o_emoji      (w_em)
    );

    assign m_axis_tvalid = w_cmd.out_valid;
    assign m_axis_tdata  = {5'd0, w_em, w_ri, w_brk};
endmodule

>>> dv/grapheme_cluster_boundary_core_tb.sv
// Self-checking testbench for grapheme_cluster_boundary_core: directed table, then random
// loads and boundary queries under several table_count settings, checked against a predictor.
// Depends on gcb_pkg and the RTL of grapheme_cluster_boundary_core.
`timescale 1ns / 1ps
module grapheme_cluster_boundary_core_tb;
    import gcb_pkg::*;

    localparam int unsigned SLOTS     = 2048;
    localparam int unsigned IDLE_MAX  = 4000;   // cycles without any accepted word
    localparam int unsigned HOLD_LEN  = 400;    // long receiver hold-off
    localparam logic        REQ_LOAD  = 1'b0;
    localparam logic        REQ_QUERY = 1'b1;

    typedef logic [MASK_W-1:0] t_mask;

    // one seam decision: {emoji, ri_odd, boundary}
    typedef struct packed {
        logic emoji;
        logic ri_odd;
        logic brk;
    } t_seam;

    typedef struct {
        logic            req;
        logic [10:0]     idx;
        logic [CP_W-1:0] lo;
        logic [CP_W-1:0] hi;
        logic [CLS_W-1:0] cls;
        logic [CP_W-1:0] cpl;
        logic [CP_W-1:0] cpr;
        logic            st;
        bit              typed;   // expected result given in the row
        t_seam           res;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [11:0]  i_cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic         s_axis_tuser;
    logic [103:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [7:0]   m_axis_tdata;

    grapheme_cluster_boundary_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // Shadow of the block: range table, seam flags and table_count.
    logic [CP_W-1:0]  rng_first [SLOTS];
    logic [CP_W-1:0]  rng_last  [SLOTS];
    logic [CLS_W-1:0] rng_class [SLOTS];
    bit               slot_written [SLOTS];
    int unsigned      written_prefix;
    logic             ri_odd_q;
    logic             emoji_q;
    logic [11:0]      scan_count;

    t_seam seam_q[$];      // decisions still owed by the block
    t_row  directed[$];
    int    mismatches;
    int    hold_req;       // long hold-offs asked for by the stimulus
    int    hold_done;      // and carried out by the receiver
    int    idle_cycles;
    int    burst_left;
    logic [CP_W-1:0] chain_cp;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bitmask of every class whose range holds cp, over the searched slots.
    function automatic t_mask class_mask(logic [CP_W-1:0] cp);
        t_mask m;
        int    n;
        m = '0;
        n = (scan_count > SLOTS) ? int'(SLOTS) : int'(scan_count);
        for (int i = 0; i < n; i++) begin
            if (cp >= rng_first[i] && cp <= rng_last[i]) m[rng_class[i]] = 1'b1;
        end
        return m;
    endfunction

    function automatic bit printable(logic [CP_W-1:0] cp);
        return cp >= PRINT_LO && cp <= PRINT_HI;
    endfunction

    // GB3..GB999; uses the seam flags as already updated for this pair.
    function automatic logic seam_breaks(t_mask a, t_mask b);
        if (a[CLS_CR] && b[CLS_LF]) return 1'b0;
        if (a[CLS_CONTROL] || a[CLS_CR] || a[CLS_LF]) return 1'b1;
        if (b[CLS_CONTROL] || b[CLS_CR] || b[CLS_LF]) return 1'b1;
        if (a[CLS_L] && (b[CLS_L] || b[CLS_V] || b[CLS_LV] || b[CLS_LVT])) return 1'b0;
        if ((a[CLS_LV] || a[CLS_V]) && (b[CLS_V] || b[CLS_T])) return 1'b0;
        if ((a[CLS_LVT] || a[CLS_T]) && b[CLS_T]) return 1'b0;
        if (b[CLS_EXTEND] || b[CLS_ZWJ]) return 1'b0;
        if (b[CLS_SPACINGMARK]) return 1'b0;
        if (a[CLS_PREPEND]) return 1'b0;
        if (emoji_q && a[CLS_ZWJ] && b[CLS_EXTPICT]) return 1'b0;
        if (a[CLS_RI] && b[CLS_RI] && ri_odd_q) return 1'b0;
        return 1'b1;
    endfunction

    // Apply one accepted word to the shadow; returns 1 and the decision for a query.
    function automatic bit apply_word(t_row r, output t_seam res);
        t_mask a;
        t_mask b;
        logic  brk;
        res = '0;
        if (r.req == REQ_LOAD) begin
            rng_first[r.idx] = r.lo;
            rng_last[r.idx]  = r.hi;
            rng_class[r.idx] = r.cls;
            slot_written[r.idx] = 1'b1;
            while (written_prefix < SLOTS && slot_written[written_prefix])
                written_prefix++;
            return 1'b0;
        end
        if (r.st) begin
            ri_odd_q = 1'b0;
            emoji_q  = 1'b0;
        end
        if (printable(r.cpl) && printable(r.cpr)) begin
            brk = 1'b1;
        end else begin
            a = class_mask(r.cpl);
            b = class_mask(r.cpr);
            if (b[CLS_RI]) ri_odd_q = a[CLS_RI] ? ~ri_odd_q : 1'b0;
            if (!emoji_q && a[CLS_EXTPICT] && (b[CLS_ZWJ] || b[CLS_EXTEND])) begin
                emoji_q = 1'b1;
            end else if (emoji_q && ((a[CLS_ZWJ] && b[CLS_EXTPICT]) ||
                                     (a[CLS_EXTEND] && b[CLS_EXTEND]) ||
                                     (a[CLS_EXTEND] && b[CLS_ZWJ]) ||
                                     (a[CLS_EXTPICT] && b[CLS_ZWJ]) ||
                                     (a[CLS_EXTPICT] && b[CLS_EXTEND]))) begin
                emoji_q = 1'b1;
            end else begin
                emoji_q = 1'b0;
            end
            brk = seam_breaks(a, b);
        end
        res.brk    = brk;
        res.ri_odd = ri_odd_q;
        res.emoji  = emoji_q;
        return 1'b1;
    endfunction

    function automatic logic [103:0] pack_word(t_row r);
        return {4'b0000, r.st, r.cpr, r.cpl, r.cls, r.hi, r.lo, r.idx};
    endfunction

    // Code point in the directed map for class c (slots 0..13 cover c*16 blocks).
    function automatic logic [CP_W-1:0] dir_cp(int c);
        return CP_W'(32'h1000 + c * 16 + 3);
    endfunction

    function automatic t_row mk_load(int idx, int lo, int hi, int cls);
        t_row r;
        r = '{default: '0};
        r.req = REQ_LOAD;
        r.idx = 11'(idx);
        r.lo  = CP_W'(lo);
        r.hi  = CP_W'(hi);
        r.cls = CLS_W'(cls);
        r.cpl = CP_W'($urandom);
        r.cpr = CP_W'($urandom);
        return r;
    endfunction

    function automatic t_row mk_query(int cpl, int cpr, bit st);
        t_row r;
        r = '{default: '0};
        r.req = REQ_QUERY;
        r.idx = 11'($urandom);
        r.lo  = CP_W'($urandom);
        r.hi  = CP_W'($urandom);
        r.cls = CLS_W'($urandom);
        r.cpl = CP_W'(cpl);
        r.cpr = CP_W'(cpr);
        r.st  = st;
        return r;
    endfunction

    // Random code point: mostly inside the class blocks of the random table.
    function automatic int rand_cp();
        int k;
        k = $urandom_range(0, 99);
        if (k < 75) return $urandom_range(0, 15) * 64 + $urandom_range(0, 63);
        if (k < 85) return $urandom_range(32'h20, 32'h7E);
        if (k < 93) return $urandom_range(0, 32'h10FFFF);
        return $urandom_range(0, 32'h7F);
    endfunction

    function automatic t_row rand_load(int idx);
        int lo;
        int hi;
        int k;
        int cls;
        cls = $urandom_range(0, 15);
        lo  = cls * 64 + $urandom_range(0, 40);
        hi  = lo + $urandom_range(0, 30);
        k   = $urandom_range(0, 99);
        if (k < 8) begin
            hi = lo - 1 - $urandom_range(0, 20);    // empty range
            if (hi < 0) hi = 0;
            if (lo == 0) lo = 5;
        end else if (k < 13) begin
            lo = $urandom_range(0, 32'h10FFFF);
            hi = $urandom_range(0, 32'h10FFFF);
        end
        return mk_load(idx, lo, hi, cls);
    endfunction

    function automatic void seam_queue_push(t_seam s);
        seam_q.push_back(s);
    endfunction

    // Sender: offer one word and hold it until the block takes it.
    task automatic send_word(t_row r);
        t_seam res;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.req;
        s_axis_tdata  <= pack_word(r);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (apply_word(r, res)) seam_queue_push(r.typed ? r.res : res);
    endtask

    // Bursty sender: after each word either go on or drop valid for a while.
    task automatic sender_gap();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(10, 30)
                                                   : $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic wait_results();
        while (seam_q.size() != 0) @(posedge i_clk);
    endtask

    // Block idle: owed results in, then the scan time of a load-only tail.
    task automatic set_scan_count(logic [11:0] n);
        s_axis_tvalid <= 1'b0;
        wait_results();
        repeat (int'(scan_count > SLOTS ? SLOTS : scan_count) + 8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= n;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        scan_count = n;
    endtask

    // Receiver: own stall pattern, changing mode now and then, plus long hold-offs.
    initial begin : receiver
        int mode;
        int cyc;
        int held;
        mode = 0;
        cyc  = 0;
        held = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc % 64 == 0) mode = $urandom_range(0, 2);
            if (hold_req > hold_done) begin
                m_axis_tready <= 1'b0;
                held++;
                if (held >= HOLD_LEN) begin
                    held = 0;
                    hold_done++;
                end
            end else begin
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= (cyc % 5) < 3;
                    default: m_axis_tready <= $urandom_range(0, 3) != 0;
                endcase
            end
        end
    end

    // Result checker: every word taken on m_axis against the oldest expectation.
    always @(posedge i_clk) begin
        t_seam want;
        t_seam got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_seam'(m_axis_tdata[2:0]);
            if (seam_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result word %b", m_axis_tdata);
            end else begin
                want = seam_q.pop_front();
                if (got !== want || m_axis_tdata[7:3] !== 5'b0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: brk/ri/emoji expected %b%b%b got %b%b%b (word %b)",
                                 want.brk, want.ri_odd, want.emoji,
                                 got.brk, got.ri_odd, got.emoji, m_axis_tdata);
                end
            end
        end
    end

    // Watchdog: cycles in which neither side moves a word.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_MAX) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        t_row r;
        int   phase_counts[7];
        int   phase_items[7];
        int   n;
        int   cap;
        int   pick;
        int   cls_seq[$];

        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        i_rst_n       <= 1'b0;
        mismatches     = 0;
        hold_req       = 0;
        hold_done      = 0;
        idle_cycles    = 0;
        burst_left     = 0;
        written_prefix = 0;
        ri_odd_q       = 1'b0;
        emoji_q        = 1'b0;
        scan_count     = '0;
        foreach (slot_written[i]) slot_written[i] = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part, table_count 0: nothing classifies, results read off directly
        r = mk_query(0, 0, 1'b0);
        r.typed = 1'b1; r.res = '{emoji: 1'b0, ri_odd: 1'b0, brk: 1'b1};
        directed.push_back(r);
        r = mk_query(32'h20, 32'h7E, 1'b1);                 // printable pair, edges
        r.typed = 1'b1; r.res = '{emoji: 1'b0, ri_odd: 1'b0, brk: 1'b1};
        directed.push_back(r);
        r = mk_query(32'h10FFFF, 32'h10FFFF, 1'b0);         // top code point
        r.typed = 1'b1; r.res = '{emoji: 1'b0, ri_odd: 1'b0, brk: 1'b1};
        directed.push_back(r);
        directed.push_back(mk_load(2047, 32'h10FFFF, 32'h10FFFF, 15));  // last slot
        foreach (directed[i]) begin
            send_word(directed[i]);
            sender_gap();
        end
        directed.delete();

        // class map: slot c holds class c at 0x1000+c*16; ExtPict overlaps the RI block;
        // slot 15 is an empty range with an unused class
        for (int c = 0; c < 14; c++)
            send_word(mk_load(c, 32'h1000 + c * 16, 32'h1000 + c * 16 + 15, c));
        send_word(mk_load(14, 32'h1050, 32'h105F, CLS_EXTPICT));
        send_word(mk_load(15, 32'h10FFFF, 32'h1100, 15));
        set_scan_count(12'd16);

        // ---- directed part, checked against the predictor
        directed.push_back(mk_query(dir_cp(CLS_CR), dir_cp(CLS_LF), 1'b1));
        directed.push_back(mk_query(dir_cp(CLS_LF), dir_cp(CLS_L), 1'b0));
        directed.push_back(mk_query(dir_cp(CLS_L), dir_cp(CLS_CONTROL), 1'b0));
        directed.push_back(mk_query(dir_cp(CLS_L), dir_cp(CLS_LVT), 1'b0));
        directed.push_back(mk_query(dir_cp(CLS_LV), dir_cp(CLS_T), 1'b0));
        directed.push_back(mk_query(dir_cp(CLS_LVT), dir_cp(CLS_T), 1'b0));
        directed.push_back(mk_query(dir_cp(CLS_V), dir_cp(CLS_SPACINGMARK), 1'b0));
        directed.push_back(mk_query(dir_cp(CLS_PREPEND), dir_cp(CLS_V), 1'b0));
        directed.push_back(mk_query(dir_cp(CLS_EXTPICT), dir_cp(CLS_EXTEND), 1'b0));
        directed.push_back(mk_query(dir_cp(CLS_EXTEND), dir_cp(CLS_ZWJ), 1'b0));
        directed.push_back(mk_query(dir_cp(CLS_ZWJ), dir_cp(CLS_EXTPICT), 1'b0));
        directed.push_back(mk_query(32'h41, 32'h42, 1'b0));  // printable keeps flags
        directed.push_back(mk_query(dir_cp(CLS_RI), dir_cp(CLS_RI), 1'b1));
        directed.push_back(mk_query(dir_cp(CLS_RI), dir_cp(CLS_RI), 1'b0));
        directed.push_back(mk_query(dir_cp(CLS_RI), dir_cp(CLS_RI), 1'b0));
        directed.push_back(mk_query(32'h1200, dir_cp(CLS_RI), 1'b0));   // empty range cp
        foreach (directed[i]) begin
            send_word(directed[i]);
            sender_gap();
        end

        // ---- random part: phases of table_count, single-entry and empty scans among them
        phase_counts = '{37, 1, 0, 64, 8, 100, 16};
        phase_items  = '{50, 20, 20, 10, 10, 20, 40};
        chain_cp = CP_W'(rand_cp());
        foreach (phase_counts[p]) begin
            cap = phase_counts[p] > SLOTS ? SLOTS : phase_counts[p];
            // every slot that a query will search holds a loaded range
            s_axis_tvalid <= 1'b0;
            wait_results();
            for (int i = written_prefix; i < cap; i++) send_word(rand_load(i));
            set_scan_count(12'(phase_counts[p]));
            if (p == 0) hold_req++;
            n = 0;
            while (n < phase_items[p]) begin
                pick = $urandom_range(0, 99);
                if (pick < 20) begin
                    // reload a searched slot, now and then a far one
                    if (cap > 0 && pick < 16) r = rand_load($urandom_range(0, cap - 1));
                    else r = rand_load($urandom_range(0, SLOTS - 1));
                end else if (pick < 30) begin
                    r = mk_query(rand_cp(), rand_cp(), $urandom_range(0, 1));   // noise
                    chain_cp = r.cpr;
                end else begin
                    // text run: right side of one seam is the left of the next
                    if (cls_seq.size() == 0) begin
                        case ($urandom_range(0, 3))
                            0: cls_seq = '{CLS_EXTPICT, CLS_EXTEND, CLS_ZWJ, CLS_EXTPICT};
                            1: cls_seq = '{CLS_RI, CLS_RI, CLS_RI, CLS_RI, CLS_RI};
                            2: cls_seq = '{CLS_L, CLS_V, CLS_T, CLS_LVT, CLS_T};
                            default: cls_seq = '{CLS_CR, CLS_LF, CLS_PREPEND, CLS_SPACINGMARK};
                        endcase
                        r = mk_query(chain_cp, cls_seq[0] * 64 + $urandom_range(0, 63),
                                     $urandom_range(0, 4) == 0);
                    end else begin
                        r = mk_query(chain_cp, cls_seq[0] * 64 + $urandom_range(0, 63), 1'b0);
                    end
                    if ($urandom_range(0, 9) == 0) r.cpr = CP_W'(rand_cp());  // broken run
                    void'(cls_seq.pop_front());
                    chain_cp = r.cpr;
                end
                send_word(r);
                n++;
                sender_gap();
            end
        end

        s_axis_tvalid <= 1'b0;
        wait_results();
        repeat (int'(scan_count > SLOTS ? SLOTS : scan_count) + 20) @(posedge i_clk);
        if (mismatches == 0 && seam_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

>>> files.f
src/gcb_pkg.sv
src/gcb_ram.sv
src/gcb_ctrl.sv
src/gcb_dp.sv
src/grapheme_cluster_boundary_core.sv
dv/grapheme_cluster_boundary_core_tb.sv
